/* rtl/scbc_pkg.sv */
`timescale 1ns / 1ps

package scbc_pkg;

  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 32;
  localparam int TOTAL_W    = 9;
  localparam int NONEMPTY_W = 5;
  localparam int OVER_W     = 32;

  localparam int NUM_CLASSES_DEF = 16;
  localparam int CLASS_DEPTH_DEF = 16;
  localparam int PAGE_SHIFT_DEF  = 12;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // per-request result leaving the class control
  typedef struct packed {
    logic                  hit;
    logic                  too_large;
    logic                  pop;
    logic [TOTAL_W-1:0]    cached_total;
    logic [NONEMPTY_W-1:0] nonempty_classes;
    logic [OVER_W-1:0]     too_large_count;
  } res_t;

endpackage

/* rtl/scbc_if.sv */
`timescale 1ns / 1ps

interface scbc_in_if;
  import scbc_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 op;
  logic [SIZE_W-1:0]   size_bytes;
  logic [ADDR_W-1:0]   buffer_addr;

  modport source (output valid, output op, output size_bytes, output buffer_addr,
                  input ready);
  modport sink   (input valid, input op, input size_bytes, input buffer_addr,
                  output ready);
endinterface

interface scbc_out_if;
  import scbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ADDR_W-1:0]     addr_out;
  logic                  hit;
  logic                  too_large;
  logic [TOTAL_W-1:0]    cached_total;
  logic [NONEMPTY_W-1:0] nonempty_classes;
  logic [OVER_W-1:0]     too_large_count;

  modport source (output valid, output addr_out, output hit, output too_large,
                  output cached_total, output nonempty_classes,
                  output too_large_count, input ready);
  modport sink   (input valid, input addr_out, input hit, input too_large,
                  input cached_total, input nonempty_classes,
                  input too_large_count, output ready);
endinterface

/* rtl/scbc_ram.sv */
`timescale 1ns / 1ps

module scbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/scbc_ctrl.sv */
`timescale 1ns / 1ps

module scbc_ctrl #(
  parameter int NUM_CLASSES = scbc_pkg::NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = scbc_pkg::CLASS_DEPTH_DEF,
  parameter int PAGE_SHIFT  = scbc_pkg::PAGE_SHIFT_DEF,
  parameter int RA_W        = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          accept,
  input  scbc_pkg::op_t                 op,
  input  logic [scbc_pkg::SIZE_W-1:0]   size_bytes,
  input  logic [scbc_pkg::ADDR_W-1:0]   buffer_addr,
  output logic                          ram_we,
  output logic [RA_W-1:0]               ram_waddr,
  output logic [scbc_pkg::ADDR_W-1:0]   ram_wdata,
  output logic                          ram_re,
  output logic [RA_W-1:0]               ram_raddr,
  output scbc_pkg::res_t                res
);
  import scbc_pkg::*;

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CNT_IW = $clog2(CLASS_DEPTH + 1);
  localparam int TOT_IW = $clog2(NUM_CLASSES * CLASS_DEPTH + 1);
  localparam int NE_IW  = $clog2(NUM_CLASSES + 1);
  localparam int PG_W   = SIZE_W + 1 - PAGE_SHIFT;

  logic                cache_enable_r;
  logic [PTR_W-1:0]    head_r  [NUM_CLASSES];
  logic [PTR_W-1:0]    tail_r  [NUM_CLASSES];
  logic [CNT_IW-1:0]   count_r [NUM_CLASSES];
  logic [TOT_IW-1:0]   total_r, total_nxt;
  logic [NE_IW-1:0]    nonempty_r, nonempty_nxt;
  logic [OVER_W-1:0]   oversize_r, oversize_nxt;

  logic [SIZE_W:0]     size_sum;
  logic [PG_W-1:0]     pages;
  logic                too_large, in_range;
  logic [CLS_W-1:0]    idx;
  logic [CNT_IW-1:0]   cnt;
  logic [PTR_W-1:0]    head, tail, head_nxt, tail_nxt;
  logic                pop, push, over_inc;
  logic [RA_W-1:0]     base;
  logic [TOT_IW+TOTAL_W-1:0]   total_ext;
  logic [NE_IW+NONEMPTY_W-1:0] ne_ext;

  // round up to pages; page count p picks class p-1
  assign size_sum  = {1'b0, size_bytes} + (SIZE_W+1)'((64'd1 << PAGE_SHIFT) - 64'd1);
  assign pages     = size_sum[SIZE_W:PAGE_SHIFT];
  assign too_large = pages > PG_W'(NUM_CLASSES);
  assign in_range  = !too_large && (pages != '0);
  assign idx       = in_range ? CLS_W'(pages - PG_W'(1)) : '0;

  assign cnt  = count_r[idx];
  assign head = head_r[idx];
  assign tail = tail_r[idx];

  assign head_nxt = (head == PTR_W'(CLASS_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_nxt = (tail == PTR_W'(CLASS_DEPTH - 1)) ? '0 : tail + PTR_W'(1);

  assign pop      = accept && in_range && (op == OP_ALLOC) && (cnt != '0);
  assign push     = accept && in_range && (op == OP_FREE) && cache_enable_r &&
                    (cnt != CNT_IW'(CLASS_DEPTH));
  assign over_inc = accept && too_large && (op == OP_ALLOC) && (oversize_r != '1);

  always_comb begin
    total_nxt    = total_r;
    nonempty_nxt = nonempty_r;
    oversize_nxt = oversize_r;
    if (push) begin
      total_nxt = total_r + TOT_IW'(1);
      if (cnt == '0) begin
        nonempty_nxt = nonempty_r + NE_IW'(1);
      end
    end
    if (pop) begin
      total_nxt = total_r - TOT_IW'(1);
      if (cnt == CNT_IW'(1)) begin
        nonempty_nxt = nonempty_r - NE_IW'(1);
      end
    end
    if (over_inc) begin
      oversize_nxt = oversize_r + OVER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_enable_r <= 1'b0;
      total_r        <= '0;
      nonempty_r     <= '0;
      oversize_r     <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cache_enable_r <= cfg_wr_data;
      end
      total_r    <= total_nxt;
      nonempty_r <= nonempty_nxt;
      oversize_r <= oversize_nxt;
      if (pop) begin
        head_r[idx]  <= head_nxt;
        count_r[idx] <= cnt - CNT_IW'(1);
      end
      if (push) begin
        tail_r[idx]  <= tail_nxt;
        count_r[idx] <= cnt + CNT_IW'(1);
      end
    end
  end

  assign base      = RA_W'(idx) * RA_W'(CLASS_DEPTH);
  assign ram_we    = push;
  assign ram_waddr = base + RA_W'(tail);
  assign ram_wdata = buffer_addr;
  assign ram_re    = pop;
  assign ram_raddr = base + RA_W'(head);

  assign total_ext = {{TOTAL_W{1'b0}}, total_nxt};
  assign ne_ext    = {{NONEMPTY_W{1'b0}}, nonempty_nxt};

  always_comb begin
    res                  = '0;
    res.hit              = pop || push;
    res.too_large        = too_large;
    res.pop              = pop;
    res.cached_total     = total_ext[TOTAL_W-1:0];
    res.nonempty_classes = ne_ext[NONEMPTY_W-1:0];
    res.too_large_count  = oversize_nxt;
  end

`ifndef ASSERT_OFF
  a_pop_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && push))
    else $error("pop and push in one transfer");

  a_push_total: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> total_r == $past(total_r) + TOT_IW'(1))
    else $error("cached total did not follow push");

  a_over_count: assert property (@(posedge clk) disable iff (!rst_n)
    over_inc |=> oversize_r == $past(oversize_r) + OVER_W'(1))
    else $error("oversize count did not advance");
`endif

endmodule

/* rtl/size_class_buffer_cache.sv */
`timescale 1ns / 1ps

// Size-class buffer cache: freed buffers kept in one FIFO per page count.
// in_req  : valid/ready request, op (alloc/free), size_bytes, buffer_addr.
// out_res : valid/ready result, one per request: addr_out, hit, too_large,
//           cached_total, nonempty_classes, too_large_count.
// cfg_wr_en/cfg_wr_data write cache_enable; write only while idle.
// Result path: the class state, the slot RAM read and the middle-stage result
// register are written on the input transfer edge, then the output register
// takes them when out_res.ready or an empty output stage lets the stage move.
// Throughput: one request per cycle while in_req.ready is high; the class
// head/tail/count registers are updated in the transfer cycle, so
// back-to-back requests to one class need no forwarding.
// Stall: a result waiting in the output register does not block input;
// one more request is held in the middle stage, after which in_req.ready
// drops until out_res.ready frees a slot.
// Reset (rst_n low, synchronous): all classes empty, totals and the
// oversize counter zero, caching disabled. Slot RAM is not cleared.

module size_class_buffer_cache #(
  parameter int NUM_CLASSES = scbc_pkg::NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = scbc_pkg::CLASS_DEPTH_DEF,
  parameter int PAGE_SHIFT  = scbc_pkg::PAGE_SHIFT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  scbc_in_if.sink      in_req,
  scbc_out_if.source   out_res
);
  import scbc_pkg::*;

  localparam int SLOTS = NUM_CLASSES * CLASS_DEPTH;
  localparam int RA_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic              accept;
  logic              s1_move;
  logic              s1_valid_r;
  res_t              s1_res_r;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic              ram_we, ram_re;
  logic [RA_W-1:0]   ram_waddr, ram_raddr;
  logic [ADDR_W-1:0] ram_wdata, ram_rdata;

  assign s1_move      = !out_valid_r || out_res.ready;
  assign in_req.ready = !s1_valid_r || s1_move;
  assign accept       = in_req.valid && in_req.ready;

  scbc_ctrl #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_DEPTH (CLASS_DEPTH),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .RA_W        (RA_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .op          (in_req.op),
    .size_bytes  (in_req.size_bytes),
    .buffer_addr (in_req.buffer_addr),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .res         (res)
  );

  scbc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
    if (s1_move && s1_valid_r) begin
      out_res_r  <= s1_res_r;
      out_addr_r <= s1_res_r.pop ? ram_rdata : '0;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.addr_out         = out_addr_r;
  assign out_res.hit              = out_res_r.hit;
  assign out_res.too_large        = out_res_r.too_large;
  assign out_res.cached_total     = out_res_r.cached_total;
  assign out_res.nonempty_classes = out_res_r.nonempty_classes;
  assign out_res.too_large_count  = out_res_r.too_large_count;

`ifndef ASSERT_OFF
  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> $stable(ram_rdata))
    else $error("slot read data changed while stage held");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_move |=> out_valid_r)
    else $error("result lost between stages");
`endif

endmodule
